@@ hdl/cip_pkg.sv @@
// Shared types, constants and arithmetic helpers of the CIP advection block.
`default_nettype none
package cip_pkg;
	localparam int MaxNodes = 1024;
	localparam int AddrW = $clog2(MaxNodes);
	localparam int CountW = AddrW + 1;
	localparam int DataW = 32;
	localparam int CfgIdxW = 3;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_RUN  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_NODE_COUNT = 3'd0,
		REG_CELL_WIDTH = 3'd1,
		REG_INV_WIDTH  = 3'd2,
		REG_SHIFT      = 3'd3,
		REG_STEPS      = 3'd4
	} reg_idx_t;

	// Datapath operation codes issued by the controller.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_DV,      // acc <= sat(Y-D), mul t2
		OP_T1,      // mul (S+C)*ih
		OP_T3,      // mul t2*ih
		OP_T4,      // mul C*ih
		OP_A,       // mul (t1+2*t3)*ih
		OP_P1,      // mul A*xi
		OP_P2,      // mul p*xi
		OP_P3,      // mul p*xi
		OP_Q1,      // mul 3A*xi
		OP_Q2       // mul q*xi
	} op_t;

	typedef struct packed {
		logic      mem_we;     // write new value/slope at node address
		logic      old_we;     // copy current value/slope into old store
		logic      load_we;    // write loaded word into all stores
		op_t       op;
		logic      take_prod;  // capture product of previous op
	} cmd_bus_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] hi, lo;
		hi = 36'sd2147483647;
		lo = -36'sd2147483648;
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Floor shift of a 65-bit product, then saturate.
	function automatic logic signed [31:0] shsat(input logic signed [64:0] p,
			input logic sel28);
		logic signed [64:0] s;
		s = sel28 ? (p >>> 28) : (p >>> 16);
		if (s > 65'sd2147483647) return 32'sh7fffffff;
		if (s < -65'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction
endpackage
`default_nettype wire

@@ hdl/cip_stream_if.sv @@
// Valid/ready channel interfaces for command words and read results.
`default_nettype none
interface cip_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic signed [31:0] node_value;
	logic signed [31:0] node_slope;
	modport source(output valid, command, node_value, node_slope, input ready);
	modport sink(input valid, command, node_value, node_slope, output ready);
endinterface

interface cip_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] out_value;
	logic signed [31:0] out_slope;
	logic        last_node;
	modport source(output valid, out_value, out_slope, last_node, input ready);
	modport sink(input valid, out_value, out_slope, last_node, output ready);
endinterface
`default_nettype wire

@@ hdl/cip_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cip_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/cip_datapath.sv @@
// Node stores and the shared multiply/saturate unit of the CIP step.
`default_nettype none
module cip_datapath (
	input  wire logic                      clk,
	input  wire cip_pkg::cmd_bus_t         cmd,
	input  wire logic [cip_pkg::AddrW-1:0] addr,
	input  wire logic [cip_pkg::AddrW-1:0] up_addr,
	input  wire logic signed [31:0]        load_value,
	input  wire logic signed [31:0]        load_slope,
	input  wire logic [31:0]               inv_width,
	input  wire logic [31:0]               shift,
	output logic signed [31:0]             rd_value,
	output logic signed [31:0]             rd_slope
);
	logic [31:0] val_rd, slp_rd, oval_rd, oslp_rd;
	logic [31:0] val_wd, slp_wd;
	logic signed [31:0] d_q, c_q, s_q;
	logic signed [31:0] t1_q, t2_q, t3_q, a_q, b_q, p_q, q_q;
	logic signed [31:0] ma_q;
	logic [32:0] mb_q;
	logic        m28_q;
	logic signed [64:0] prod_s1;
	logic        m28_s1;
	logic signed [31:0] pr;
	cip_pkg::op_t pend_q;
	cip_pkg::op_t done_q;

	assign val_wd = cmd.load_we ? load_value : p_q;
	assign slp_wd = cmd.load_we ? load_slope : q_q;

	cip_ram #(.Width(32), .Depth(cip_pkg::MaxNodes)) u_val (.clk(clk),
		.we(cmd.mem_we | cmd.load_we), .waddr(addr), .wdata(val_wd),
		.raddr(addr), .rdata(val_rd));
	cip_ram #(.Width(32), .Depth(cip_pkg::MaxNodes)) u_slp (.clk(clk),
		.we(cmd.mem_we | cmd.load_we), .waddr(addr), .wdata(slp_wd),
		.raddr(addr), .rdata(slp_rd));
	cip_ram #(.Width(32), .Depth(cip_pkg::MaxNodes)) u_oval (.clk(clk),
		.we(cmd.old_we | cmd.load_we), .waddr(addr),
		.wdata(cmd.load_we ? load_value : val_rd), .raddr(up_addr), .rdata(oval_rd));
	cip_ram #(.Width(32), .Depth(cip_pkg::MaxNodes)) u_oslp (.clk(clk),
		.we(cmd.old_we | cmd.load_we), .waddr(addr),
		.wdata(cmd.load_we ? load_slope : slp_rd), .raddr(up_addr), .rdata(oslp_rd));

	assign rd_value = val_rd;
	assign rd_slope = slp_rd;

	// Multiplier stage: one 32x33 signed product per cycle.
	always_ff @(posedge clk) begin
		prod_s1 <= 65'(ma_q) * 65'($signed(mb_q));
		m28_s1  <= m28_q;
	end
	assign pr = cip_pkg::shsat(prod_s1, m28_s1);

	// Operand selection and result capture, sequenced by the controller.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			cip_pkg::OP_DV: begin
				d_q <= val_rd; c_q <= slp_rd; s_q <= oslp_rd;
				ma_q <= cip_pkg::sat32(36'($signed(oval_rd)) - 36'($signed(val_rd)));
				mb_q <= {1'b0, inv_width}; m28_q <= 1'b0;
			end
			cip_pkg::OP_T1: begin
				ma_q <= cip_pkg::sat32(36'(s_q) + 36'(c_q));
				mb_q <= {1'b0, inv_width}; m28_q <= 1'b0;
			end
			cip_pkg::OP_T3: begin
				ma_q <= t2_q; mb_q <= {1'b0, inv_width}; m28_q <= 1'b0;
			end
			cip_pkg::OP_T4: begin
				ma_q <= c_q; mb_q <= {1'b0, inv_width}; m28_q <= 1'b0;
			end
			cip_pkg::OP_A: begin
				ma_q <= cip_pkg::sat32(36'(t1_q) + (36'(t3_q) <<< 1));
				mb_q <= {1'b0, inv_width}; m28_q <= 1'b0;
			end
			cip_pkg::OP_P1: begin
				ma_q <= a_q; mb_q <= -{1'b0, shift}; m28_q <= 1'b1;
			end
			cip_pkg::OP_P2, cip_pkg::OP_P3: begin
				ma_q <= p_q; mb_q <= -{1'b0, shift}; m28_q <= 1'b1;
			end
			cip_pkg::OP_Q1: begin
				ma_q <= cip_pkg::sat32(36'(a_q) * 36'sd3); mb_q <= -{1'b0, shift};
				m28_q <= 1'b1;
			end
			cip_pkg::OP_Q2: begin
				ma_q <= q_q; mb_q <= -{1'b0, shift}; m28_q <= 1'b1;
			end
			default: ;
		endcase
		pend_q <= cmd.op;
	end

	// Product write-back; the op whose product arrives is tracked through pend_q and done_q.
	always_ff @(posedge clk) begin
		done_q <= pend_q;
		if (cmd.take_prod) begin
			unique case (done_q)
				cip_pkg::OP_DV: t2_q <= pr;
				cip_pkg::OP_T1: t1_q <= pr;
				cip_pkg::OP_T3: t3_q <= pr;
				cip_pkg::OP_T4: begin
					b_q <= cip_pkg::sat32(36'(t3_q) * 36'sd3 + 36'(t1_q) + 36'(pr));
				end
				cip_pkg::OP_A: a_q <= pr;
				cip_pkg::OP_P1: p_q <= cip_pkg::sat32(36'(pr) + 36'(b_q));
				cip_pkg::OP_P2: p_q <= cip_pkg::sat32(36'(pr) + 36'(c_q));
				cip_pkg::OP_P3: p_q <= cip_pkg::sat32(36'(pr) + 36'(d_q));
				cip_pkg::OP_Q1: begin
					q_q <= cip_pkg::sat32(36'(pr) +
						36'(cip_pkg::sat32(36'(b_q) <<< 1)));
				end
				cip_pkg::OP_Q2: q_q <= cip_pkg::sat32(36'(pr) + 36'(c_q));
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/cip_ctrl.sv @@
// Command sequencer: loads, reads, and the step/node/operation walk of a run.
`default_nettype none
module cip_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [1:0]                 in_command,
	output logic                            in_ready,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            last_node,
	output logic                            cap_read,
	input  wire logic [cip_pkg::CountW-1:0] node_count,
	input  wire logic [15:0]                step_count,
	output cip_pkg::cmd_bus_t               cmd,
	output logic [cip_pkg::AddrW-1:0]       addr,
	output logic [cip_pkg::AddrW-1:0]       up_addr
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_COPY = 6'b000100,
		S_COPYW= 6'b001000,
		S_NODE = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [cip_pkg::AddrW-1:0] ld_ptr_q, rd_ptr_q, node_q;
	logic [15:0] step_q;
	logic [4:0]  seq_q;
	logic [cip_pkg::CountW-1:0] n_act;
	logic [cip_pkg::AddrW-1:0] last_idx;
	logic last_q;

	// Clamp the node count to 2..MaxNodes.
	always_comb begin
		if (node_count < cip_pkg::CountW'(2)) n_act = cip_pkg::CountW'(2);
		else if (node_count > cip_pkg::CountW'(cip_pkg::MaxNodes))
			n_act = cip_pkg::CountW'(cip_pkg::MaxNodes);
		else n_act = node_count;
	end
	assign last_idx = cip_pkg::AddrW'(n_act - cip_pkg::CountW'(1));

	logic [cip_pkg::AddrW-1:0] ld_eff, rd_eff;
	assign ld_eff = ({1'b0, ld_ptr_q} >= n_act) ? '0 : ld_ptr_q;
	assign rd_eff = ({1'b0, rd_ptr_q} >= n_act) ? '0 : rd_ptr_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign last_node = last_q;
	assign up_addr = (node_q == '0) ? last_idx : node_q - cip_pkg::AddrW'(1);

	// Address and command decode for the current state.
	always_comb begin
		cmd = '0;
		cmd.op = cip_pkg::OP_NOP;
		addr = node_q;
		cap_read = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				addr = ld_eff;
				if (in_valid && in_command == cip_pkg::CMD_LOAD) cmd.load_we = 1'b1;
				if (in_valid && in_command == cip_pkg::CMD_READ) addr = rd_eff;
			end
			S_READ: cap_read = 1'b1;
			S_COPYW: cmd.old_we = 1'b1;
			S_NODE: begin
				cmd.take_prod = 1'b1;
				case (seq_q)
					5'd1: cmd.op = cip_pkg::OP_DV;
					5'd2: cmd.op = cip_pkg::OP_T1;
					5'd4: cmd.op = cip_pkg::OP_T3;
					5'd5: cmd.op = cip_pkg::OP_T4;
					5'd8: cmd.op = cip_pkg::OP_A;
					5'd11: cmd.op = cip_pkg::OP_P1;
					5'd12: cmd.op = cip_pkg::OP_Q1;
					5'd14: cmd.op = cip_pkg::OP_P2;
					5'd15: cmd.op = cip_pkg::OP_Q2;
					5'd17: cmd.op = cip_pkg::OP_P3;
					5'd20: cmd.mem_we = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ld_ptr_q <= '0; rd_ptr_q <= '0; node_q <= '0;
			step_q <= '0; seq_q <= '0; last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					case (in_command)
						cip_pkg::CMD_LOAD:
							ld_ptr_q <= (ld_eff == last_idx) ? '0 : ld_eff + 1'b1;
						cip_pkg::CMD_READ: begin
							last_q <= (rd_eff == last_idx);
							rd_ptr_q <= (rd_eff == last_idx) ? '0 : rd_eff + 1'b1;
							state_q <= S_READ;
						end
						cip_pkg::CMD_RUN: begin
							ld_ptr_q <= '0; rd_ptr_q <= '0;
							node_q <= '0; step_q <= '0;
							if (step_count != 16'd0) state_q <= S_COPY;
						end
						default: ;
					endcase
				end
				S_READ: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				S_COPY: state_q <= S_COPYW;
				S_COPYW: begin
					if (node_q == last_idx) begin
						node_q <= '0; seq_q <= '0; state_q <= S_NODE;
					end else begin
						node_q <= node_q + 1'b1; state_q <= S_COPY;
					end
				end
				S_NODE: begin
					if (seq_q == 5'd20) begin
						seq_q <= '0;
						if (node_q == last_idx) begin
							node_q <= '0;
							if (step_q + 16'd1 == step_count) state_q <= S_IDLE;
							else begin
								step_q <= step_q + 16'd1; state_q <= S_COPY;
							end
						end else node_q <= node_q + 1'b1;
					end else seq_q <= seq_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/cip_advection_step.sv @@
// Top level of the CIP cubic upwind advection block.
// Load: into all node stores. Read: via S_READ to a result held in an output register.
// Run: each of step_count steps first copies every node into the old store, then
// runs every node through the shared 32x33 multiplier sequence.
// Reset sets pointers, state machine and config registers to their reset values;
// node stores are undefined until loaded.
`default_nettype none
module cip_advection_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	cip_in_if.sink                             in_ch,
	cip_out_if.source                          out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [cip_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	logic [cip_pkg::CountW-1:0] node_count_q;
	logic [31:0] cell_width_q, inv_width_q, shift_q;
	logic [15:0] steps_q;
	cip_pkg::cmd_bus_t cmd;
	logic [cip_pkg::AddrW-1:0] addr, up_addr;
	logic signed [31:0] rd_value, rd_slope;
	logic cap_read;
	logic signed [31:0] out_value_q, out_slope_q;
	logic unused_cw;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= cip_pkg::CountW'(2);
			cell_width_q <= '0; inv_width_q <= '0; shift_q <= '0; steps_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cip_pkg::REG_NODE_COUNT: node_count_q <= cfg_data[cip_pkg::CountW-1:0];
				cip_pkg::REG_CELL_WIDTH: cell_width_q <= cfg_data;
				cip_pkg::REG_INV_WIDTH:  inv_width_q <= cfg_data;
				cip_pkg::REG_SHIFT:      shift_q <= cfg_data;
				cip_pkg::REG_STEPS:      steps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end
	assign unused_cw = ^cell_width_q;

	cip_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid),
		.in_command(in_ch.command), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
		.out_ready(out_ch.ready), .last_node(out_ch.last_node), .cap_read(cap_read),
		.node_count(node_count_q), .step_count(steps_q), .cmd(cmd), .addr(addr),
		.up_addr(up_addr));

	cip_datapath u_dp (.clk(clk), .cmd(cmd), .addr(addr), .up_addr(up_addr),
		.load_value(in_ch.node_value), .load_slope(in_ch.node_slope),
		.inv_width(inv_width_q), .shift(shift_q), .rd_value(rd_value),
		.rd_slope(rd_slope));

	// Output word register.
	always_ff @(posedge clk) begin
		if (cap_read) begin
			out_value_q <= rd_value; out_slope_q <= rd_slope;
		end
	end
	assign out_ch.out_value = out_value_q;
	assign out_ch.out_slope = out_slope_q;
endmodule
`default_nettype wire

@@ hdl/cip_checker.sv @@
// Port-level checker for the CIP advection block, bound to the top level.
`default_nettype none
module cip_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	// Block never accepts a word while a result is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept with pending result");
	// A result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	// A taken result frees the input side.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("no return to idle");
endmodule

bind cip_advection_step cip_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready));
`default_nettype wire
